>>> rtl/core/ssg_pkg.sv
`default_nettype none
package ssg_pkg;

  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned NUM_W     = 17;
  localparam int unsigned SPEED_W   = 8;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 20;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_CMD    = 2'd1;
  localparam logic [OP_W-1:0] OP_SWITCH = 2'd2;

  localparam logic [ID_W-1:0] ID_FORWARD = 8'h54;
  localparam logic [ID_W-1:0] ID_REVERSE = 8'h55;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 20'd500000;
  localparam logic [NUM_W-1:0]     NUMERATOR_RST = 17'd100000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/ssg_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ssg_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ssg_pkg::NUM_W-1:0]   dividend,
  input  wire logic [ssg_pkg::SPEED_W-1:0] divisor,
  output logic                             done,
  output logic [ssg_pkg::NUM_W-1:0]        quotient
);

  localparam int unsigned CNT_W = $clog2(ssg_pkg::NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ssg_pkg::NUM_W - 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [ssg_pkg::SPEED_W-1:0] rem_r, rem_nxt;
  logic [ssg_pkg::SPEED_W-1:0] dvs_r, dvs_nxt;
  logic [ssg_pkg::NUM_W-1:0]   quo_r, quo_nxt;
  logic [ssg_pkg::SPEED_W:0]   rem_shift;
  logic [ssg_pkg::SPEED_W:0]   rem_diff;
  logic                        fits;

  assign rem_shift = {rem_r, quo_r[ssg_pkg::NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs_r};
  assign fits      = rem_shift >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back in SPEED_W bits
      rem_nxt = fits ? rem_diff[ssg_pkg::SPEED_W-1:0] : rem_shift[ssg_pkg::SPEED_W-1:0];
      quo_nxt = {quo_r[ssg_pkg::NUM_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/core/stepper_step_generator.sv
`default_nettype none
// Step/direction pulse generator for a stepper driver. Each request is a
// microsecond tick, a speed command or a limit-switch change, and each yields
// one result with the pin levels and run/blocked status after the event.
// Ticks, switch changes, unknown ids and stop commands are accepted, then their
// result is presented. A forward/reverse command with nonzero speed recomputes
// the half-period (numerator / speed) on a restoring divider, one quotient bit
// per cycle. The steps are: accept, 17 divide steps, load the quotient and
// present the result.
// The input is not ready until the previous result has been taken.
// Configuration writes are always accepted; write them only while idle.
module stepper_step_generator #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ssg_pkg::OP_W-1:0]       in_operation,
  input  wire logic [ssg_pkg::ID_W-1:0]       in_message_id_low,
  input  wire logic [ssg_pkg::SPEED_W-1:0]    in_speed_byte,
  input  wire logic                           in_switch_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_step_level,
  output logic                                out_direction_level,
  output logic                                out_running,
  output logic                                out_blocked,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ssg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssg_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > ssg_pkg::TIMEOUT_W) ? COUNT_WIDTH : ssg_pkg::TIMEOUT_W;
  localparam logic [COUNT_WIDTH-1:0] WD_MAX = '1;

  ssg_pkg::state_t state_r, state_nxt;

  logic [ssg_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [ssg_pkg::NUM_W-1:0]     numerator_r;
  logic                          invert_r;

  logic [ssg_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic                        rev_r, rev_nxt;
  logic [ssg_pkg::NUM_W-1:0]   hp_r, hp_nxt;
  logic [ssg_pkg::NUM_W-1:0]   intv_r, intv_nxt;
  logic [COUNT_WIDTH-1:0]      wd_r, wd_nxt;
  logic                        step_r, step_nxt;
  logic                        dir_r, dir_nxt;
  logic                        limit_r, limit_nxt;

  logic [COUNT_WIDTH-1:0]    wd_inc;
  logic                      run_tick, blk_tick;
  logic                      run_now;
  logic                      div_start, div_done;
  logic [ssg_pkg::NUM_W-1:0] div_quotient;

  ssg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (numerator_r),
    .divisor  (in_speed_byte),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign wd_inc   = (wd_r == WD_MAX) ? wd_r : wd_r + COUNT_WIDTH'(1);
  assign run_tick = (speed_r != '0) && (CMP_W'(wd_inc) <= CMP_W'(timeout_r));
  assign blk_tick = run_tick && limit_r && (rev_r == invert_r);
  assign run_now  = (speed_r != '0) && (CMP_W'(wd_r) <= CMP_W'(timeout_r));

  assign in_ready            = (state_r == ssg_pkg::ST_IDLE);
  assign out_valid           = (state_r == ssg_pkg::ST_RESULT);
  assign out_step_level      = step_r;
  assign out_direction_level = dir_r;
  assign out_running         = run_now;
  assign out_blocked         = run_now && limit_r && (rev_r == invert_r);
  assign cfg_ready           = 1'b1;

  always_comb begin
    state_nxt = state_r;
    speed_nxt = speed_r;
    rev_nxt   = rev_r;
    hp_nxt    = hp_r;
    intv_nxt  = intv_r;
    wd_nxt    = wd_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    limit_nxt = limit_r;
    div_start = 1'b0;
    case (state_r)
      ssg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ssg_pkg::ST_RESULT;
          case (in_operation)
            ssg_pkg::OP_TICK: begin
              wd_nxt = wd_inc;
              if (run_tick) begin
                if (blk_tick) begin
                  intv_nxt = '0;
                end else if (intv_r == '0) begin
                  dir_nxt  = ~rev_r;
                  step_nxt = ~step_r;
                  intv_nxt = (hp_r == '0) ? '0 : hp_r - ssg_pkg::NUM_W'(1);
                end else begin
                  intv_nxt = intv_r - ssg_pkg::NUM_W'(1);
                end
              end
            end
            ssg_pkg::OP_CMD: begin
              wd_nxt = '0;
              if (in_message_id_low inside {ssg_pkg::ID_FORWARD, ssg_pkg::ID_REVERSE}) begin
                speed_nxt = in_speed_byte;
                rev_nxt   = (in_message_id_low == ssg_pkg::ID_REVERSE);
                intv_nxt  = '0;
                if (in_speed_byte != '0) begin
                  div_start = 1'b1;
                  state_nxt = ssg_pkg::ST_DIV;
                end else begin
                  hp_nxt = '0;
                end
              end
            end
            ssg_pkg::OP_SWITCH: begin
              limit_nxt = in_switch_level;
            end
            default: begin
            end
          endcase
        end
      end
      ssg_pkg::ST_DIV: begin
        if (div_done) begin
          hp_nxt    = div_quotient;
          state_nxt = ssg_pkg::ST_RESULT;
        end
      end
      ssg_pkg::ST_RESULT: begin
        if (out_ready) begin
          state_nxt = ssg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssg_pkg::ST_IDLE;
      timeout_r   <= ssg_pkg::TIMEOUT_RST;
      numerator_r <= ssg_pkg::NUMERATOR_RST;
      invert_r    <= 1'b0;
      speed_r     <= '0;
      rev_r       <= 1'b0;
      hp_r        <= '0;
      intv_r      <= '0;
      wd_r        <= '0;
      step_r      <= 1'b0;
      dir_r       <= 1'b0;
      limit_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      speed_r <= speed_nxt;
      rev_r   <= rev_nxt;
      hp_r    <= hp_nxt;
      intv_r  <= intv_nxt;
      wd_r    <= wd_nxt;
      step_r  <= step_nxt;
      dir_r   <= dir_nxt;
      limit_r <= limit_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          ssg_pkg::REG_TIMEOUT:   timeout_r   <= cfg_data[ssg_pkg::TIMEOUT_W-1:0];
          ssg_pkg::REG_NUMERATOR: numerator_r <= cfg_data[ssg_pkg::NUM_W-1:0];
          ssg_pkg::REG_INVERT:    invert_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> test/stepper_step_generator_tb.sv
`default_nettype none
module stepper_step_generator_tb;
  import ssg_pkg::*;

  localparam int unsigned COUNT_WIDTH = 20;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 175;

  typedef struct packed {
    logic step_level;
    logic direction_level;
    logic running;
    logic blocked;
  } pin_state_t;

  // Tracks the generator's state and queues the pin levels each request should produce.
  class step_scoreboard;
    logic [TIMEOUT_W-1:0]   timeout_ticks;
    logic [NUM_W-1:0]       numerator;
    logic                   invert;
    logic [SPEED_W-1:0]     speed;
    logic                   reverse;
    logic [NUM_W-1:0]       half_period;
    logic [NUM_W-1:0]       interval;
    logic [COUNT_WIDTH-1:0] watchdog;
    logic                   step_pin;
    logic                   dir_pin;
    logic                   pressed;
    pin_state_t             pending[$];
    int                     errors;
    int                     toggles;
    int                     blocked_seen;
    int                     expired_seen;

    function new();
      timeout_ticks = TIMEOUT_RST;
      numerator     = NUMERATOR_RST;
      invert        = 1'b0;
      speed         = '0;
      reverse       = 1'b0;
      half_period   = '0;
      interval      = '0;
      watchdog      = '0;
      step_pin      = 1'b0;
      dir_pin       = 1'b0;
      pressed       = 1'b0;
      errors        = 0;
      toggles       = 0;
      blocked_seen  = 0;
      expired_seen  = 0;
    endfunction

    function bit is_running();
      return speed != 0 && watchdog <= timeout_ticks;
    endfunction

    function bit is_blocked();
      return is_running() && pressed && reverse == invert;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_TIMEOUT:   timeout_ticks = data[TIMEOUT_W-1:0];
        REG_NUMERATOR: numerator = data[NUM_W-1:0];
        REG_INVERT:    invert = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [SPEED_W-1:0] spd, logic lvl);
      pin_state_t r;
      case (op)
        OP_TICK: begin
          if (watchdog != '1) watchdog++;
          if (is_running()) begin
            if (is_blocked()) begin
              interval = '0;
            end else if (interval == 0) begin
              dir_pin  = !reverse;
              step_pin = !step_pin;
              interval = (half_period == 0) ? '0 : half_period - 1'b1;
              toggles++;
            end else begin
              interval--;
            end
          end else if (speed != 0) begin
            expired_seen++;
          end
        end
        OP_CMD: begin
          watchdog = '0;
          if (id == ID_FORWARD || id == ID_REVERSE) begin
            speed       = spd;
            reverse     = (id == ID_REVERSE);
            half_period = (spd != 0) ? numerator / spd : '0;
            interval    = '0;
          end
        end
        OP_SWITCH: pressed = lvl;
        default: ;
      endcase
      r.step_level      = step_pin;
      r.direction_level = dir_pin;
      r.running         = is_running();
      r.blocked         = is_blocked();
      if (r.blocked) blocked_seen++;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic s, logic d, logic r, logic b);
      pin_state_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual step %0b dir %0b run %0b blk %0b",
                 $time, s, d, r, b);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("step_level", want.step_level, s);
      compare_field("direction_level", want.direction_level, d);
      compare_field("running", want.running, r);
      compare_field("blocked", want.blocked, b);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = '0;
  logic [ID_W-1:0]      in_message_id_low = '0;
  logic [SPEED_W-1:0]   in_speed_byte = '0;
  logic                 in_switch_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_step_level;
  logic                 out_direction_level;
  logic                 out_running;
  logic                 out_blocked;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  step_scoreboard sb;
  int sent = 0;
  int cfg_writes = 0;
  bit burst = 1'b0;
  bit hold_off = 1'b0;

  stepper_step_generator #(.COUNT_WIDTH(COUNT_WIDTH)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_message_id_low   (in_message_id_low),
    .in_speed_byte       (in_speed_byte),
    .in_switch_level     (in_switch_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_step_level      (out_step_level),
    .out_direction_level (out_direction_level),
    .out_running         (out_running),
    .out_blocked         (out_blocked),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("[stepper_step_generator] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_step_level, out_direction_level, out_running, out_blocked);
  end

  // Result side: random back-pressure, a long hold-off on request, none in burst phases.
  initial begin : receiver
    int n;
    int r;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (burst) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 6);
        end else begin
          out_ready <= 1'b0;
          n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [SPEED_W-1:0] spd, input logic lvl);
    int gap;
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_message_id_low <= id;
    in_speed_byte     <= spd;
    in_switch_level   <= lvl;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, id, spd, lvl);
    sent++;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic set_config(input logic [CFG_DAT_W-1:0] tmo, input logic [NUM_W-1:0] num,
                            input logic inv);
    cfg_write(REG_UNUSED, CFG_DAT_W'($urandom));
    cfg_write(REG_TIMEOUT, tmo);
    cfg_write(REG_NUMERATOR, CFG_DAT_W'(num));
    cfg_write(REG_INVERT, CFG_DAT_W'(inv));
    cfg_valid <= 1'b0;
  endtask

  // Mostly a command followed by a run of ticks with occasional switch changes; otherwise a few requests of any kind.
  task automatic random_segment();
    int kind;
    int len;
    int pick;
    logic [ID_W-1:0] id;
    logic [SPEED_W-1:0] spd;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      pick = $urandom_range(0, 99);
      id = (pick < 45) ? ID_FORWARD : (pick < 85) ? ID_REVERSE : ID_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      spd = (pick < 10) ? '0 : (pick < 20) ? '1 : SPEED_W'($urandom_range(1, 255));
      send_request(OP_CMD, id, spd, 1'($urandom));
      len = $urandom_range(3, 40);
      repeat (len) begin
        if ($urandom_range(0, 99) < 8)
          send_request(OP_SWITCH, ID_W'($urandom), SPEED_W'($urandom), 1'($urandom));
        else
          send_request(OP_TICK, ID_W'($urandom), SPEED_W'($urandom), 1'($urandom));
      end
    end else begin
      len = $urandom_range(1, 6);
      repeat (len)
        send_request(OP_W'($urandom_range(0, 3)), ID_W'($urandom), SPEED_W'($urandom),
                     1'($urandom));
    end
  endtask

  task automatic run_phase(input logic [CFG_DAT_W-1:0] tmo, input logic [NUM_W-1:0] num,
                           input logic inv, input int items, input bit no_idle,
                           input bit squeeze);
    int target;
    wait_drained();
    set_config(tmo, num, inv);
    burst = no_idle;
    if (squeeze) hold_off = 1'b1;
    target = sent + items;
    while (sent < target) random_segment();
  endtask

  initial begin : main
    logic [CFG_DAT_W-1:0] tmo;
    logic [NUM_W-1:0] num;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: idle tick, both directions, blocking, foreign ids, stop.
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);
    send_request(OP_CMD, ID_FORWARD, 8'hFF, 1'b0);
    send_request(OP_TICK, 8'hFF, 8'hFF, 1'b1);
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);
    send_request(OP_SWITCH, 8'h00, 8'h00, 1'b1);
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);
    send_request(OP_CMD, ID_REVERSE, 8'h01, 1'b1);
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);
    send_request(OP_SWITCH, 8'hFF, 8'hFF, 1'b0);
    send_request(OP_CMD, 8'h00, 8'h00, 1'b0);
    send_request(OP_CMD, 8'hFF, 8'hFF, 1'b1);
    send_request(OP_W'(3), 8'hFF, 8'hFF, 1'b1);
    send_request(OP_CMD, ID_FORWARD, 8'h00, 1'b0);
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);

    // Zero timeout and zero numerator, switch inverted.
    wait_drained();
    set_config('0, '0, 1'b1);
    send_request(OP_CMD, ID_REVERSE, 8'h07, 1'b0);
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);
    send_request(OP_CMD, ID_FORWARD, 8'hFF, 1'b0);
    send_request(OP_SWITCH, 8'h00, 8'h00, 1'b1);
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);
    send_request(OP_CMD, ID_REVERSE, 8'h03, 1'b0);
    send_request(OP_TICK, 8'h00, 8'h00, 1'b0);

    run_phase('1, '1, 1'b1, 150, 1'b0, 1'b0);
    run_phase(CFG_DAT_W'(1), NUM_W'(1), 1'b0, 150, 1'b0, 1'b1);
    for (int i = 0; i < 8; i++) begin
      tmo = ($urandom_range(0, 99) < 50) ? CFG_DAT_W'($urandom_range(1, 60))
                                         : CFG_DAT_W'($urandom_range(61, 1048575));
      num = ($urandom_range(0, 99) < 80) ? NUM_W'($urandom_range(1, 3000))
                                         : NUM_W'($urandom_range(1, 131071));
      run_phase(tmo, num, 1'($urandom), PHASE_ITEMS, i == 3, 1'b0);
    end

    wait_drained();
    burst = 1'b0;
    repeat (40) @(posedge clk);
    $display("Covered %0d requests across %0d register writes: %0d step toggles,",
             sent, cfg_writes, sb.toggles);
    $display("%0d blocked results and %0d ticks with the watchdog expired",
             sb.blocked_seen, sb.expired_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[stepper_step_generator] OK");
    end else begin
      $display("[stepper_step_generator] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
